FILE: rtl/acpb_pkg.sv
// Shared types, constants and helper functions for the permutation table builder.
package acpb_pkg;

  localparam int MaxOrder   = 12;
  localparam int EntryW     = 12;
  localparam int SizeW      = 13;
  localparam int ReqW       = 17;
  localparam int OrderW     = 5;
  localparam int TableDepth = 1 << MaxOrder;
  localparam int PickBit    = 14;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_STARTED = 3'd0,
    STS_STEP    = 3'd1,
    STS_DONE    = 3'd2,
    STS_READ    = 3'd3,
    STS_IGNORED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN_WR,
    ST_STEP_HI,
    ST_STEP_LO,
    ST_READ_OUT,
    ST_NOP_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_begin;
    logic do_step;
    logic do_read;
    logic do_ignore;
    logic wr_zero;
    logic wr_hi;
    logic wr_lo;
    logic out_read;
  } acpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic building;
  } acpb_stat_t;

  // Table order: bit length of (req - 1), capped at the maximum order.
  function automatic logic [OrderW-1:0] order_of(input logic [ReqW-1:0] req);
    logic [ReqW-1:0]   s;
    logic [OrderW-1:0] len;
    begin
      s   = req - ReqW'(1);
      len = '0;
      if (req <= ReqW'(1)) begin
        len = '0;
      end else if (s[ReqW-1:MaxOrder] != '0) begin
        len = OrderW'(MaxOrder);
      end else begin
        for (int i = 0; i < MaxOrder; i++) begin
          if (s[i]) len = OrderW'(i + 1);
        end
      end
      return len;
    end
  endfunction

  // Index mask with the lowest order bits set.
  function automatic logic [EntryW-1:0] mask_of(input logic [OrderW-1:0] order);
    logic [EntryW-1:0] m;
    begin
      for (int i = 0; i < EntryW; i++) begin
        m[i] = (OrderW'(i) < order);
      end
      return m;
    end
  endfunction

endpackage

FILE: rtl/acpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acpb_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/acpb_ctrl.sv
// Controller state machine: sequences begin, build step, read and ignored beats.
module acpb_ctrl
  import acpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  action_e    action_i,
  input  acpb_stat_t stat_i,
  output logic       busy,
  output logic       strobe_o,
  output acpb_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = ST_IDLE;
    busy     = (state_q == ST_STEP_HI);
    strobe_o = 1'b0;
    cmd_o    = '0;
    accept   = start && !busy;

    case (state_q)
      ST_STEP_HI:  cmd_o.wr_hi = 1'b1;
      ST_STEP_LO:  begin
        cmd_o.wr_lo = 1'b1;
        strobe_o    = 1'b1;
      end
      ST_BEGIN_WR: begin
        cmd_o.wr_zero = 1'b1;
        strobe_o      = 1'b1;
      end
      ST_READ_OUT: begin
        cmd_o.out_read = 1'b1;
        strobe_o       = 1'b1;
      end
      ST_NOP_OUT:  strobe_o = 1'b1;
      ST_IDLE:     strobe_o = 1'b0;
      default:     strobe_o = 1'b0;
    endcase

    if (state_q == ST_STEP_HI) begin
      state_d = ST_STEP_LO;
    end else if (accept) begin
      case (action_i)
        ACT_BEGIN: begin
          cmd_o.do_begin = 1'b1;
          state_d        = ST_BEGIN_WR;
        end
        ACT_STEP: begin
          if (stat_i.building) begin
            cmd_o.do_step = 1'b1;
            state_d       = ST_STEP_HI;
          end else begin
            cmd_o.do_ignore = 1'b1;
            state_d         = ST_NOP_OUT;
          end
        end
        ACT_READ: begin
          cmd_o.do_read = 1'b1;
          state_d       = ST_READ_OUT;
        end
        default: begin
          cmd_o.do_ignore = 1'b1;
          state_d         = ST_NOP_OUT;
        end
      endcase
    end
  end

endmodule

FILE: rtl/acpb_dp.sv
// Datapath: build state registers, table memory, forwarding and result fields.
module acpb_dp
  import acpb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ReqW-1:0]   cfg_wdata_i,
  input  acpb_cmd_t         cmd_i,
  input  logic [30:0]       random_word_i,
  input  logic [EntryW-1:0] index_i,
  output acpb_stat_t        stat_o,
  output logic [2:0]        status_o,
  output logic [EntryW-1:0] entry_o,
  output logic [SizeW-1:0]  table_size_o
);

  logic [ReqW-1:0]   req_q;
  logic [OrderW-1:0] order_q, order_d;
  logic [EntryW-1:0] mask_q;
  logic [OrderW-1:0] level_q;
  logic [SizeW-1:0]  half_q, half_d;
  logic [EntryW-1:0] walk_q;
  logic              building_q;
  logic              built_q;
  status_e           status_q;

  logic [EntryW-1:0] lo_addr_q, hi_addr_q, lo_data_q;
  logic              pick_q;

  logic              ram_we;
  logic [EntryW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic              fwd_hit_q;
  logic [EntryW-1:0] fwd_data_q;
  logic [EntryW-1:0] rd_data;

  assign order_d = order_of(req_q);
  assign half_d  = half_q << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q      <= '0;
      order_q    <= '0;
      mask_q     <= '0;
      level_q    <= '0;
      half_q     <= '0;
      walk_q     <= '0;
      building_q <= 1'b0;
      built_q    <= 1'b0;
      status_q   <= STS_IGNORED;
    end else begin
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
      if (cmd_i.do_begin) begin
        order_q    <= order_d;
        mask_q     <= mask_of(order_d);
        level_q    <= (order_d != '0) ? OrderW'(1) : '0;
        half_q     <= (order_d != '0) ? SizeW'(1) : '0;
        walk_q     <= '0;
        building_q <= (order_d != '0);
        built_q    <= 1'b1;
        status_q   <= STS_STARTED;
      end else if (cmd_i.do_step) begin
        status_q <= STS_STEP;
        if (walk_q != '0) begin
          walk_q <= walk_q - EntryW'(1);
        end else begin
          level_q <= level_q + OrderW'(1);
          half_q  <= half_d;
          if (level_q >= order_q) begin
            building_q <= 1'b0;
            status_q   <= STS_DONE;
          end else begin
            walk_q <= half_d[EntryW-1:0] - EntryW'(1);
          end
        end
      end else if (cmd_i.do_read) begin
        status_q <= STS_READ;
      end else if (cmd_i.do_ignore) begin
        status_q <= STS_IGNORED;
      end
    end
  end

  // Step operands are captured on the accepting edge, before the walk moves on.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_step) begin
      lo_addr_q <= walk_q;
      hi_addr_q <= walk_q + half_q[EntryW-1:0];
      pick_q    <= random_word_i[PickBit];
    end
    if (cmd_i.wr_hi) begin
      lo_data_q <= {rd_data[EntryW-2:0], pick_q};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd_i.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hi_addr_q;
      ram_wdata = {rd_data[EntryW-2:0], ~pick_q};
    end else if (cmd_i.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = lo_addr_q;
      ram_wdata = lo_data_q;
    end else if (cmd_i.wr_zero) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = '0;
    end
  end

  assign ram_raddr = cmd_i.do_read ? (index_i & mask_q) : walk_q;

  acpb_ram #(
    .Width(EntryW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A read on the same edge as a write to that address takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
  end

  assign rd_data = fwd_hit_q ? fwd_data_q : ram_rdata;

  assign stat_o.building = building_q;
  assign status_o        = status_q;
  assign entry_o         = (cmd_i.out_read && built_q) ? rd_data : '0;
  assign table_size_o    = (order_q != '0) ? ({1'b0, mask_q} + SizeW'(1)) : '0;

endmodule

FILE: rtl/anticorrelated_permutation_builder_core.sv
// Top level of the anticorrelated permutation table builder.
//
// Usage: load requested_size through cfg_we_i/cfg_wdata_i while the block is
// idle. An item is taken on a rising edge with start high and busy low;
// action_i selects begin (0), build step (1), read (2) or nothing (3).
// A begin fixes the table order and clears entry 0; then one build step
// per random word grows the table until status reports build complete.
// A read returns the masked entry at index_i.
// Each item gives exactly one result beat, shown for one cycle with
// strobe_o high. Begin, read and ignored items show it in the cycle after
// the item is taken, so they can follow one per cycle. A build step shows
// it in ST_STEP_LO, after ST_STEP_HI, because the single write port of the
// table memory writes the upper copy and then the lower copy; busy is high
// in ST_STEP_HI, so no new item is taken until the step's result cycle. A
// new item may be taken on the edge that ends a result cycle.
// The receiver cannot stall: strobe_o marks the only cycle of each beat.
// Reset clears the order, mask, build state and the configuration
// register; the table memory itself is not cleared.
module anticorrelated_permutation_builder_core
  import acpb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ReqW-1:0]   cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action_i,
  input  logic [30:0]       random_word_i,
  input  logic [EntryW-1:0] index_i,
  output logic              strobe_o,
  output logic [2:0]        status_o,
  output logic [EntryW-1:0] entry_o,
  output logic [SizeW-1:0]  table_size_o
);

  acpb_cmd_t  cmd;
  acpb_stat_t stat;

  acpb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .action_i(action_e'(action_i)),
    .stat_i  (stat),
    .busy    (busy),
    .strobe_o(strobe_o),
    .cmd_o   (cmd)
  );

  acpb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .random_word_i(random_word_i),
    .index_i      (index_i),
    .stat_o       (stat),
    .status_o     (status_o),
    .entry_o      (entry_o),
    .table_size_o (table_size_o)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the anticorrelated permutation table builder core.
`timescale 1ns / 100ps

module tb_top
  import acpb_pkg::*;
;

  localparam int StallLimit = 2000;
  localparam int TotalItems = 1400;

  typedef struct packed {
    status_e                status;
    logic [EntryW-1:0]      entry;
    logic [SizeW-1:0]       size;
  } beat_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [ReqW-1:0]        cfg_val;
    action_e                act;
    logic [30:0]            word;
    logic [EntryW-1:0]      idx;
    logic                   typed;
    beat_t                  known;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ReqW-1:0]   cfg_wdata_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action_i = '0;
  logic [30:0]       random_word_i = '0;
  logic [EntryW-1:0] index_i = '0;
  logic              strobe_o;
  logic [2:0]        status_o;
  logic [EntryW-1:0] entry_o;
  logic [SizeW-1:0]  table_size_o;

  anticorrelated_permutation_builder_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .random_word_i(random_word_i),
    .index_i      (index_i),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .entry_o      (entry_o),
    .table_size_o (table_size_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's table and build state.
  logic [EntryW-1:0] perm_mirror [TableDepth];
  bit                ever_written [TableDepth];
  logic [ReqW-1:0]   wanted_size = '0;
  logic [OrderW-1:0] table_order = '0;
  logic [EntryW-1:0] index_mask = '0;
  logic [OrderW-1:0] build_level = '0;
  logic [SizeW-1:0]  half_span = '0;
  logic [EntryW-1:0] walk_pos = '0;
  bit                building = 1'b0;

  beat_t pending_beats[$];
  int    fail_count = 0;
  int    items_sent = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;
  bit    gaps_on = 1'b1;

  plan_row_t directed_plan [30] = '{
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'h5A5, 1'b1, '{STS_READ,    12'd0, 13'd0}},
    '{1'b1, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b1, '{STS_STARTED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'hFFF, 1'b1, '{STS_READ,    12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h7FFF_FFFF, 12'h000, 1'b1, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_RSVD,  31'h7FFF_FFFF, 12'hFFF, 1'b1, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b1, 17'd2,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b1, '{STS_STARTED, 12'd0, 13'd2}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_4000, 12'h000, 1'b1, '{STS_DONE,    12'd0, 13'd2}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'h000, 1'b1, '{STS_READ,    12'd1, 13'd2}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'hFFF, 1'b1, '{STS_READ,    12'd0, 13'd2}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_0000, 12'h000, 1'b1, '{STS_IGNORED, 12'd0, 13'd2}},
    '{1'b1, 17'd5,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h7FFF_FFFF, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'h003, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_4000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b1, 17'd65536, ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b1, '{STS_STARTED, 12'd0, 13'd4096}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'h000, 1'b1, '{STS_READ,    12'd0, 13'd4096}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_STEP,  31'h0000_3FFF, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b1, 17'd4097,  ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b1, '{STS_STARTED, 12'd0, 13'd4096}},
    '{1'b1, 17'd1,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b0, '{STS_IGNORED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_BEGIN, 31'h0000_0000, 12'h000, 1'b1, '{STS_STARTED, 12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_READ,  31'h0000_0000, 12'hABC, 1'b1, '{STS_READ,    12'd0, 13'd0}},
    '{1'b0, 17'd0,     ACT_RSVD,  31'h0000_0000, 12'h000, 1'b1, '{STS_IGNORED, 12'd0, 13'd0}}
  };

  function automatic logic [OrderW-1:0] size_to_order(input logic [ReqW-1:0] req);
    logic [ReqW-1:0] rest;
    int              bits;
    if (req <= 1) return '0;
    rest = req - 1'b1;
    bits = 0;
    while (rest != 0) begin
      bits++;
      rest = rest >> 1;
    end
    return OrderW'((bits > MaxOrder) ? MaxOrder : bits);
  endfunction

  // Advances the mirror by one item and returns the beat the block should give.
  function automatic beat_t predict_beat(input action_e act, input logic [30:0] word,
                                         input logic [EntryW-1:0] idx);
    beat_t             b;
    logic [EntryW-1:0] lo;
    logic [EntryW-1:0] hi;
    logic [EntryW-1:0] v;
    b.status = STS_IGNORED;
    b.entry  = '0;
    case (act)
      ACT_BEGIN: begin
        table_order = size_to_order(wanted_size);
        index_mask  = EntryW'((32'd1 << table_order) - 1);
        perm_mirror[0]  = '0;
        ever_written[0] = 1'b1;
        build_level = OrderW'(table_order != 0);
        half_span   = SizeW'(table_order != 0);
        walk_pos    = '0;
        building    = (table_order != 0);
        b.status    = STS_STARTED;
      end
      ACT_STEP: begin
        if (building) begin
          lo = walk_pos;
          hi = lo + half_span[EntryW-1:0];
          v  = perm_mirror[lo] << 1;
          perm_mirror[lo] = v;
          perm_mirror[hi] = v;
          // The pick bit decides which of the two copies is made odd.
          if (word[PickBit]) perm_mirror[lo] = v + 1'b1;
          else perm_mirror[hi] = v + 1'b1;
          ever_written[lo] = 1'b1;
          ever_written[hi] = 1'b1;
          b.status = STS_STEP;
          if (walk_pos != 0) begin
            walk_pos = walk_pos - 1'b1;
          end else begin
            build_level = build_level + 1'b1;
            half_span   = half_span << 1;
            if (build_level > table_order) begin
              building = 1'b0;
              b.status = STS_DONE;
            end else begin
              walk_pos = EntryW'(half_span - 1'b1);
            end
          end
        end
      end
      ACT_READ: begin
        b.entry  = perm_mirror[idx & index_mask];
        b.status = STS_READ;
      end
      default: ;
    endcase
    b.size = (table_order != 0) ? SizeW'(index_mask) + 1'b1 : '0;
    return b;
  endfunction

  // A read index whose masked position has been written at some point.
  function automatic logic [EntryW-1:0] pick_index();
    logic [EntryW-1:0] idx;
    idx = '0;
    for (int t = 0; t < 8; t++) begin
      idx = EntryW'($urandom());
      if (ever_written[idx & index_mask]) return idx;
    end
    return idx & ~index_mask;
  endfunction

  task automatic maybe_gap();
    if (!gaps_on) return;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic send_item(input action_e act, input logic [30:0] word,
                           input logic [EntryW-1:0] idx, input bit typed,
                           input beat_t known);
    beat_t predicted;
    start         <= 1'b1;
    action_i      <= act;
    random_word_i <= word;
    index_i       <= idx;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predicted = predict_beat(act, word, idx);
    pending_beats.push_back(typed ? known : predicted);
    items_sent++;
    maybe_gap();
  endtask

  task automatic send_random(input action_e act);
    logic [EntryW-1:0] idx;
    idx = (act == ACT_READ) ? pick_index() : EntryW'($urandom());
    send_item(act, 31'($urandom()), idx, 1'b0, beat_t'{STS_IGNORED, '0, '0});
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [ReqW-1:0] req);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= req;
    @(posedge clk_i);
    wanted_size = req;
    cfg_we_i <= 1'b0;
  endtask

  // Sets a size, begins a build and feeds steps with reads and noise in between.
  // A partial build is abandoned and later restarted by the next begin.
  task automatic build_sequence(input logic [ReqW-1:0] req, input bit to_end);
    int steps_left;
    int r;
    gaps_on = ($urandom_range(0, 3) != 0);
    write_size(req);
    send_random(ACT_BEGIN);
    steps_left = (1 << table_order) - 1;
    if (!to_end) steps_left = $urandom_range(0, (steps_left > 300) ? 300 : steps_left);
    while (steps_left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_random(ACT_READ);
      end else if (r < 18) begin
        send_random(ACT_RSVD);
      end else begin
        send_random(ACT_STEP);
        steps_left--;
      end
    end
    repeat ($urandom_range(0, 4)) send_random(ACT_READ);
    if ($urandom_range(0, 3) == 0) send_random(ACT_STEP);
  endtask

  initial begin
    int r;
    int ord;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_cfg) begin
        write_size(directed_plan[n].cfg_val);
      end else begin
        send_item(directed_plan[n].act, directed_plan[n].word, directed_plan[n].idx,
                  directed_plan[n].typed, directed_plan[n].known);
      end
    end

    while (items_sent < TotalItems) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        ord = $urandom_range(1, 7);
        build_sequence(ReqW'($urandom_range((1 << (ord - 1)) + 1, 1 << ord)), 1'b1);
      end else if (r == 6) begin
        build_sequence(ReqW'($urandom_range(2, 256)), 1'b0);
      end else if (r == 7) begin
        build_sequence(ReqW'($urandom_range(TableDepth + 1, 65536)), 1'b0);
      end else if (r == 8) begin
        build_sequence(ReqW'($urandom_range(0, 1)), 1'b1);
      end else begin
        gaps_on = 1'b1;
        repeat ($urandom_range(3, 12)) send_random(action_e'($urandom_range(0, 3)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_beats.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Result checker: every strobe beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && strobe_o !== 1'b0) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: status %0d entry %0d table_size %0d",
               status_o, entry_o, table_size_o);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (entry_o !== want.entry) begin
          $error("entry: expected %0d, got %0d", want.entry, entry_o);
          fail_count++;
        end
        if (table_size_o !== want.size) begin
          $error("table_size: expected %0d, got %0d", want.size, table_size_o);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither an item nor a result beat moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || strobe_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
